### hw/rtl/imhpq_pkg.sv
`timescale 1ns / 1ps

package imhpq_pkg;

   localparam int IMHPQ_HEAP_CAPACITY = 1024;
   localparam int IMHPQ_ID_SPACE      = 1024;
   localparam int IMHPQ_KEY_WIDTH     = 32;

   localparam int ID_W     = 10;
   localparam int PORT_KEY_W = 32;
   localparam int STATUS_W = 3;
   localparam int OCC_W    = 11;

   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_REMOVE = 2'd1;
   localparam logic [1:0] ACT_UPDATE = 2'd2;
   localparam logic [1:0] ACT_GET    = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_DUP      = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd4;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_PM_WAIT,
      ST_HP_WAIT,
      ST_RM_ROOT,
      ST_RM_LAST,
      ST_UP_CHK,
      ST_UP_CMP,
      ST_DN_CHK,
      ST_DN_LEFT,
      ST_DN_RIGHT,
      ST_DN_CMP,
      ST_PLACE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic lt;
      logic eq;
   } cmp_flags_type;

endpackage

### hw/rtl/imhpq_cmp.sv
`timescale 1ns / 1ps

module imhpq_cmp #(
   parameter int KEY_WIDTH = imhpq_pkg::IMHPQ_KEY_WIDTH
) (
   input  logic signed [KEY_WIDTH-1:0] a,
   input  logic signed [KEY_WIDTH-1:0] b,
   output imhpq_pkg::cmp_flags_type    flags
);
   import imhpq_pkg::*;

   always_comb begin
      flags.lt = (a < b);
      flags.eq = (a == b);
   end

endmodule

### hw/rtl/indexed_min_heap_priority_queue.sv
`timescale 1ns / 1ps

// Indexed binary min-heap of (id, key) pairs with signed keys. After reset the block
// clears its id-to-slot map, one entry per cycle, over all ID_SPACE entries, and holds
// req_ready low meanwhile. An item then goes through lookup and bookkeeping states,
// from the idle state in which it is taken, and through its sift, over at most
// log2(HEAP_CAPACITY) levels: a sift-up level needs one read of the heap memory and
// one pass through the shared key comparator, and a sift-down level needs up to two
// of each. A new item is taken only when the previous one is finished; a finished
// result waits in the output register while the next item is already accepted.
module indexed_min_heap_priority_queue #(
   parameter int HEAP_CAPACITY = imhpq_pkg::IMHPQ_HEAP_CAPACITY,
   parameter int ID_SPACE      = imhpq_pkg::IMHPQ_ID_SPACE,
   parameter int KEY_WIDTH     = imhpq_pkg::IMHPQ_KEY_WIDTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [1:0]                            req_action,
   input  logic [imhpq_pkg::ID_W-1:0]            req_item_id,
   input  logic signed [imhpq_pkg::PORT_KEY_W-1:0] req_key_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [imhpq_pkg::STATUS_W-1:0]        rsp_status,
   output logic [imhpq_pkg::ID_W-1:0]            rsp_out_id,
   output logic signed [imhpq_pkg::PORT_KEY_W-1:0] rsp_out_key,
   output logic [imhpq_pkg::OCC_W-1:0]           rsp_occupancy
);
   import imhpq_pkg::*;

   localparam int SW   = $clog2(HEAP_CAPACITY + 1);
   localparam int HAW  = $clog2(HEAP_CAPACITY);
   localparam int PAW  = $clog2(ID_SPACE);
   localparam int EW   = ID_W + KEY_WIDTH;

   state_type state_ff, state_in;

   logic [1:0]                  act_ff, act_in;
   logic [ID_W-1:0]             id_ff, id_in;
   logic signed [KEY_WIDTH-1:0] key_ff, key_in;
   logic [ID_W-1:0]             node_id_ff, node_id_in;
   logic signed [KEY_WIDTH-1:0] node_key_ff, node_key_in;
   logic [SW-1:0]               slot_ff, slot_in;
   logic [ID_W-1:0]             pick_id_ff, pick_id_in;
   logic signed [KEY_WIDTH-1:0] pick_key_ff, pick_key_in;
   logic [SW-1:0]               pick_slot_ff, pick_slot_in;
   logic [ID_W-1:0]             rid_ff, rid_in;
   logic signed [KEY_WIDTH-1:0] rkey_ff, rkey_in;
   logic [STATUS_W-1:0]         status_ff, status_in;
   logic [SW-1:0]               count_ff, count_in;
   logic [PAW-1:0]              clr_ff, clr_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]         rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]             rsp_id_ff, rsp_id_in;
   logic [PORT_KEY_W-1:0]       rsp_key_ff, rsp_key_in;
   logic [OCC_W-1:0]            rsp_occ_ff, rsp_occ_in;

   logic [EW-1:0]   heap_mem [HEAP_CAPACITY];
   logic [EW-1:0]   heap_rd_ff;
   logic            heap_we;
   logic [HAW-1:0]  heap_waddr, heap_raddr;
   logic [EW-1:0]   heap_wdata;

   logic [SW-1:0]   pm_mem [ID_SPACE];
   logic [SW-1:0]   pm_rd_ff;
   logic            pm_we;
   logic [PAW-1:0]  pm_waddr, pm_raddr;
   logic [SW-1:0]   pm_wdata;

   logic signed [KEY_WIDTH-1:0] cmp_a, cmp_b;
   cmp_flags_type               cmp_flags;

   logic [ID_W-1:0]             rd_id;
   logic signed [KEY_WIDTH-1:0] rd_key;
   logic signed [KEY_WIDTH-1:0] port_key;
   logic [PORT_KEY_W-1:0]       key_ext;
   logic [SW:0]                 left_slot;
   logic                        in_range;
   logic                        req_fire, rsp_load;

   generate
      if (KEY_WIDTH <= PORT_KEY_W) begin : g_narrow_key
         assign port_key = req_key_value[KEY_WIDTH-1:0];
         assign key_ext  = PORT_KEY_W'(rkey_ff);
      end else begin : g_wide_key
         assign port_key = KEY_WIDTH'($unsigned(req_key_value));
         assign key_ext  = rkey_ff[PORT_KEY_W-1:0];
      end
   endgenerate

   assign rd_id     = heap_rd_ff[KEY_WIDTH +: ID_W];
   assign rd_key    = heap_rd_ff[KEY_WIDTH-1:0];
   assign left_slot = {slot_ff, 1'b0};
   assign in_range  = ({22'd0, id_ff} < 32'(ID_SPACE));
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   imhpq_cmp #(.KEY_WIDTH(KEY_WIDTH)) u_cmp (
      .a     (cmp_a),
      .b     (cmp_b),
      .flags (cmp_flags)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == PAW'(ID_SPACE - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_fire) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            if (act_ff == ACT_REMOVE) begin
               state_in = (count_ff == '0) ? ST_DONE : ST_RM_ROOT;
            end else begin
               state_in = in_range ? ST_PM_WAIT : ST_DONE;
            end
         end
         ST_PM_WAIT: begin
            if (act_ff == ACT_INSERT) begin
               if (pm_rd_ff != '0 || count_ff >= SW'(HEAP_CAPACITY)) state_in = ST_DONE;
               else state_in = ST_UP_CHK;
            end else begin
               if (pm_rd_ff == '0 || pm_rd_ff > count_ff) state_in = ST_DONE;
               else state_in = ST_HP_WAIT;
            end
         end
         ST_HP_WAIT: begin
            if (act_ff == ACT_GET || cmp_flags.eq) state_in = ST_DONE;
            else if (cmp_flags.lt) state_in = ST_UP_CHK;
            else state_in = ST_DN_CHK;
         end
         ST_RM_ROOT: state_in = ST_RM_LAST;
         ST_RM_LAST: begin
            state_in = (count_ff == SW'(1)) ? ST_DONE : ST_DN_CHK;
         end
         ST_UP_CHK: begin
            state_in = (slot_ff == SW'(1)) ? ST_PLACE : ST_UP_CMP;
         end
         ST_UP_CMP: begin
            state_in = cmp_flags.lt ? ST_UP_CHK : ST_PLACE;
         end
         ST_DN_CHK: begin
            state_in = (left_slot > {1'b0, count_ff}) ? ST_PLACE : ST_DN_LEFT;
         end
         ST_DN_LEFT: begin
            state_in = (left_slot < {1'b0, count_ff}) ? ST_DN_RIGHT : ST_DN_CMP;
         end
         ST_DN_RIGHT: state_in = ST_DN_CMP;
         ST_DN_CMP: begin
            state_in = cmp_flags.lt ? ST_DN_CHK : ST_PLACE;
         end
         ST_PLACE: state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      act_in       = act_ff;
      id_in        = id_ff;
      key_in       = key_ff;
      node_id_in   = node_id_ff;
      node_key_in  = node_key_ff;
      slot_in      = slot_ff;
      pick_id_in   = pick_id_ff;
      pick_key_in  = pick_key_ff;
      pick_slot_in = pick_slot_ff;
      rid_in       = rid_ff;
      rkey_in      = rkey_ff;
      status_in    = status_ff;
      count_in     = count_ff;
      clr_in       = clr_ff;
      heap_we      = 1'b0;
      heap_waddr   = HAW'(slot_ff - 1'b1);
      heap_wdata   = {node_id_ff, node_key_ff};
      heap_raddr   = '0;
      pm_we        = 1'b0;
      pm_waddr     = PAW'(node_id_ff);
      pm_wdata     = slot_ff;
      pm_raddr     = PAW'(id_ff);
      cmp_a        = pick_key_ff;
      cmp_b        = node_key_ff;
      case (state_ff)
         ST_CLEAR: begin
            pm_we    = 1'b1;
            pm_waddr = clr_ff;
            pm_wdata = '0;
            clr_in   = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (req_fire) begin
               act_in    = req_action;
               id_in     = req_item_id;
               key_in    = port_key;
               rid_in    = req_item_id;
               status_in = STATUS_OK;
            end
         end
         ST_DISPATCH: begin
            heap_raddr = '0;
            if (act_ff == ACT_REMOVE) begin
               if (count_ff == '0) status_in = STATUS_EMPTY;
            end else if (!in_range) begin
               status_in = STATUS_NOTFOUND;
            end
         end
         ST_PM_WAIT: begin
            heap_raddr = HAW'(pm_rd_ff - 1'b1);
            if (act_ff == ACT_INSERT) begin
               if (pm_rd_ff != '0) begin
                  status_in = STATUS_DUP;
               end else if (count_ff >= SW'(HEAP_CAPACITY)) begin
                  status_in = STATUS_FULL;
               end else begin
                  count_in    = count_ff + 1'b1;
                  slot_in     = count_ff + 1'b1;
                  node_id_in  = id_ff;
                  node_key_in = key_ff;
                  rkey_in     = key_ff;
               end
            end else begin
               if (pm_rd_ff == '0 || pm_rd_ff > count_ff) status_in = STATUS_NOTFOUND;
               else slot_in = pm_rd_ff;
            end
         end
         ST_HP_WAIT: begin
            cmp_a = key_ff;
            cmp_b = rd_key;
            if (act_ff == ACT_GET) begin
               rkey_in = rd_key;
            end else begin
               rkey_in     = key_ff;
               node_id_in  = id_ff;
               node_key_in = key_ff;
            end
         end
         ST_RM_ROOT: begin
            rid_in     = rd_id;
            rkey_in    = rd_key;
            heap_raddr = HAW'(count_ff - 1'b1);
         end
         ST_RM_LAST: begin
            node_id_in  = rd_id;
            node_key_in = rd_key;
            count_in    = count_ff - 1'b1;
            slot_in     = SW'(1);
            pm_we       = 1'b1;
            pm_waddr    = PAW'(rid_ff);
            pm_wdata    = '0;
         end
         ST_UP_CHK: begin
            heap_raddr = HAW'((slot_ff >> 1) - 1'b1);
         end
         ST_UP_CMP: begin
            cmp_a = node_key_ff;
            cmp_b = rd_key;
            if (cmp_flags.lt) begin
               heap_we    = 1'b1;
               heap_wdata = heap_rd_ff;
               pm_we      = 1'b1;
               pm_waddr   = PAW'(rd_id);
               slot_in    = slot_ff >> 1;
            end
         end
         ST_DN_CHK: begin
            heap_raddr = HAW'(left_slot - 1'b1);
         end
         ST_DN_LEFT: begin
            heap_raddr   = HAW'(left_slot);
            pick_id_in   = rd_id;
            pick_key_in  = rd_key;
            pick_slot_in = SW'(left_slot);
         end
         ST_DN_RIGHT: begin
            cmp_a = pick_key_ff;
            cmp_b = rd_key;
            if (!cmp_flags.lt) begin
               pick_id_in   = rd_id;
               pick_key_in  = rd_key;
               pick_slot_in = pick_slot_ff + 1'b1;
            end
         end
         ST_DN_CMP: begin
            cmp_a = pick_key_ff;
            cmp_b = node_key_ff;
            if (cmp_flags.lt) begin
               heap_we    = 1'b1;
               heap_wdata = {pick_id_ff, pick_key_ff};
               pm_we      = 1'b1;
               pm_waddr   = PAW'(pick_id_ff);
               slot_in    = pick_slot_ff;
            end
         end
         ST_PLACE: begin
            heap_we = 1'b1;
            pm_we   = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_occ_in    = rsp_occ_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_id_in     = rid_ff;
         rsp_key_in    = (status_ff == STATUS_OK) ? key_ext : '0;
         rsp_occ_in    = OCC_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         count_ff     <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      id_ff         <= id_in;
      key_ff        <= key_in;
      node_id_ff    <= node_id_in;
      node_key_ff   <= node_key_in;
      slot_ff       <= slot_in;
      pick_id_ff    <= pick_id_in;
      pick_key_ff   <= pick_key_in;
      pick_slot_ff  <= pick_slot_in;
      rid_ff        <= rid_in;
      rkey_ff       <= rkey_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   always_ff @(posedge clock) begin
      if (heap_we) heap_mem[heap_waddr] <= heap_wdata;
      heap_rd_ff <= heap_mem[heap_raddr];
   end

   always_ff @(posedge clock) begin
      if (pm_we) pm_mem[pm_waddr] <= pm_wdata;
      pm_rd_ff <= pm_mem[pm_raddr];
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_id    = rsp_id_ff;
   assign rsp_out_key   = rsp_key_ff;
   assign rsp_occupancy = rsp_occ_ff;

endmodule

### verif/indexed_min_heap_priority_queue_tb.sv
`timescale 1ns / 1ps

module indexed_min_heap_priority_queue_tb;
   import imhpq_pkg::*;

   localparam int CAP = IMHPQ_HEAP_CAPACITY;
   localparam int STALL_LIMIT = 6000;
   localparam int HOLD_CYCLES = 400;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [ID_W-1:0]       id;
      logic [PORT_KEY_W-1:0] key;
      logic [OCC_W-1:0]      occ;
   } heap_rsp_type;

   logic clock = 0;
   logic reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready;
   logic [1:0] req_action;
   logic [ID_W-1:0] req_item_id;
   logic signed [PORT_KEY_W-1:0] req_key_value;
   logic [STATUS_W-1:0] rsp_status;
   logic [ID_W-1:0] rsp_out_id;
   logic signed [PORT_KEY_W-1:0] rsp_out_key;
   logic [OCC_W-1:0] rsp_occupancy;

   heap_rsp_type expected_rsps[$];
   logic [ID_W-1:0] slot_id[1:CAP];
   logic signed [PORT_KEY_W-1:0] slot_key[1:CAP];
   int id_slot[0:IMHPQ_ID_SPACE-1];
   int heap_size;

   int mismatches = 0;
   int idle_cycles = 0;
   int items_sent = 0;
   int rsps_checked = 0;
   bit hold_rsp = 0;
   bit calm = 0;

   indexed_min_heap_priority_queue u_top (.*);

   always #5 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic swap_slots(input int a, input int b);
      logic [ID_W-1:0] tid;
      logic signed [PORT_KEY_W-1:0] tkey;
      tid = slot_id[a];
      tkey = slot_key[a];
      slot_id[a] = slot_id[b];
      slot_key[a] = slot_key[b];
      slot_id[b] = tid;
      slot_key[b] = tkey;
      id_slot[slot_id[a]] = a;
      id_slot[slot_id[b]] = b;
   endtask

   task automatic bubble_up(input int i);
      while (i > 1 && slot_key[i / 2] > slot_key[i]) begin
         swap_slots(i / 2, i);
         i = i / 2;
      end
   endtask

   task automatic bubble_down(input int i);
      int l;
      int c;
      forever begin
         l = 2 * i;
         if (l > heap_size) break;
         if (l + 1 > heap_size || slot_key[l] < slot_key[l + 1]) c = l;
         else c = l + 1;
         if (slot_key[i] <= slot_key[c]) break;
         swap_slots(i, c);
         i = c;
      end
   endtask

   task automatic heap_apply(input logic [1:0] act, input logic [ID_W-1:0] id,
                             input logic signed [PORT_KEY_W-1:0] key,
                             output heap_rsp_type r);
      int p;
      logic signed [PORT_KEY_W-1:0] old_key;
      r.status = STATUS_OK;
      r.id = id;
      r.key = '0;
      case (act)
         ACT_REMOVE: begin
            if (heap_size == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               r.id = slot_id[1];
               r.key = slot_key[1];
               slot_id[1] = slot_id[heap_size];
               slot_key[1] = slot_key[heap_size];
               id_slot[slot_id[1]] = 1;
               heap_size--;
               id_slot[r.id] = 0;
               bubble_down(1);
            end
         end
         ACT_INSERT: begin
            if (id_slot[id] != 0) begin
               r.status = STATUS_DUP;
            end else if (heap_size >= CAP) begin
               r.status = STATUS_FULL;
            end else begin
               heap_size++;
               slot_id[heap_size] = id;
               slot_key[heap_size] = key;
               id_slot[id] = heap_size;
               bubble_up(heap_size);
               r.key = key;
            end
         end
         default: begin
            p = id_slot[id];
            if (p == 0 || p > heap_size) begin
               r.status = STATUS_NOTFOUND;
            end else if (act == ACT_UPDATE) begin
               old_key = slot_key[p];
               slot_key[p] = key;
               if (key > old_key) bubble_down(p);
               else if (key < old_key) bubble_up(p);
               r.key = key;
            end else begin
               r.key = slot_key[p];
            end
         end
      endcase
      r.occ = OCC_W'(heap_size);
      if (r.status != STATUS_OK) r.key = '0;
   endtask

   task automatic send_item(input logic [1:0] act, input logic [ID_W-1:0] id,
                            input logic signed [PORT_KEY_W-1:0] key);
      heap_rsp_type r;
      int g;
      req_valid <= 1'b1;
      req_action <= act;
      req_item_id <= id;
      req_key_value <= key;
      do @(posedge clock); while (!req_ready);
      heap_apply(act, id, key, r);
      expected_rsps.push_back(r);
      items_sent++;
      g = pick_gap();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      wait (expected_rsps.size() == 0);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic signed [PORT_KEY_W-1:0] rand_key();
      if ($urandom_range(0, 9) < 6) return $signed($urandom_range(0, 16)) - 8;
      return $urandom();
   endfunction

   function automatic logic [ID_W-1:0] present_or_any_id();
      if (heap_size > 0 && $urandom_range(0, 9) < 8) return slot_id[$urandom_range(1, heap_size)];
      return ID_W'($urandom_range(0, IMHPQ_ID_SPACE - 1));
   endfunction

   task automatic test_empty_heap();
      send_item(ACT_REMOVE, 10'd1023, 32'h7fffffff);
      send_item(ACT_GET, 10'd0, '0);
      send_item(ACT_UPDATE, 10'd1023, 32'h80000000);
      wait_drained();
   endtask

   task automatic test_directed();
      send_item(ACT_INSERT, 10'd0, 32'h7fffffff);
      send_item(ACT_INSERT, 10'd1023, 32'h80000000);
      send_item(ACT_INSERT, 10'd0, 32'd5);
      send_item(ACT_INSERT, 10'd5, 32'd7);
      send_item(ACT_INSERT, 10'd6, 32'd7);
      send_item(ACT_INSERT, 10'd7, 32'd7);
      send_item(ACT_INSERT, 10'd8, 32'd7);
      send_item(ACT_GET, 10'd1023, '0);
      send_item(ACT_UPDATE, 10'd1023, 32'h7fffffff);
      send_item(ACT_UPDATE, 10'd0, 32'h80000000);
      send_item(ACT_UPDATE, 10'd5, 32'd7);
      send_item(ACT_UPDATE, 10'd6, 32'd3);
      send_item(ACT_GET, 10'd6, '0);
      send_item(ACT_GET, 10'd9, '0);
      send_item(ACT_UPDATE, 10'd9, 32'd1);
      repeat (8) send_item(ACT_REMOVE, 10'd0, '0);
      wait_drained();
   endtask

   task automatic test_fill_and_drain();
      int ids[$];
      for (int i = 0; i < CAP; i++) ids.push_back(i);
      ids.shuffle();
      calm = 1;
      foreach (ids[i]) send_item(ACT_INSERT, ID_W'(ids[i]), rand_key());
      send_item(ACT_INSERT, ID_W'(ids[0]), '0);
      send_item(ACT_GET, ID_W'(ids[5]), '0);
      calm = 0;
      for (int i = 0; i < 60; i++) send_item(ACT_REMOVE, ID_W'($urandom()), $urandom());
      wait_drained();
   endtask

   task automatic test_output_backpressure();
      hold_rsp = 1;
      for (int i = 0; i < 12; i++) send_item(ACT_INSERT, ID_W'($urandom()), rand_key());
      wait_drained();
   endtask

   task automatic test_random_mix();
      int r;
      for (int i = 0; i < 130; i++) begin
         if (i % 100 == 30) calm = 1;
         if (i % 100 == 70) calm = 0;
         r = $urandom_range(0, 99);
         if (r < 38) send_item(ACT_INSERT, ID_W'($urandom()), rand_key());
         else if (r < 62) send_item(ACT_REMOVE, ID_W'($urandom()), $urandom());
         else if (r < 82) send_item(ACT_UPDATE, present_or_any_id(), rand_key());
         else send_item(ACT_GET, present_or_any_id(), $urandom());
      end
      calm = 0;
      wait_drained();
   endtask

   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 0;
         end else if (pick_gap() == 0) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(0, 6)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      heap_rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected item: status %0d id %0d", rsp_status,
                                           rsp_out_id);
         end else begin
            e = expected_rsps.pop_front();
            rsps_checked++;
            if (rsp_status !== e.status || rsp_out_id !== e.id || rsp_out_key !== e.key
                || rsp_occupancy !== e.occ) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                           e.status, e.id, $signed(e.key), e.occ, rsp_status, rsp_out_id,
                           rsp_out_key, rsp_occupancy);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Timeout with %0d items outstanding.", expected_rsps.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      foreach (id_slot[i]) id_slot[i] = 0;
      heap_size = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_action <= ACT_INSERT;
      req_item_id <= '0;
      req_key_value <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_empty_heap();
      test_directed();
      test_fill_and_drain();
      test_output_backpressure();
      test_random_mix();
      repeat (200) @(posedge clock);
      if (expected_rsps.size() != 0) mismatches++;
      $display("Sent %0d items and checked %0d results, including a full heap and a long",
               items_sent, rsps_checked);
      $display("output stall, with mismatches counted: %0d.", mismatches);
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
